[rtl/rsc_pkg.sv]
// Shared types, constants and modular helpers for the rotor substitution cipher.
// Used by every module of the block except rsc_ram; it depends on nothing else.
package rsc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int ROTOR_COUNT   = 3;
    localparam int SYM_W         = 5;
    localparam int SUM_W         = SYM_W + 1;
    localparam int ROTOR_W       = 2;
    localparam int TABLE_ADDR_W  = $clog2(ALPHABET_SIZE);
    localparam int PIPE_STAGES   = 7;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [7:0] CASE_GAP     = 8'd32;

    localparam logic [SYM_W-1:0]   LAST_SYMBOL     = SYM_W'(ALPHABET_SIZE - 1);
    localparam logic [ROTOR_W-1:0] TABLE_REFLECTOR = 2'd3;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SET    = 2'd1,
        ACT_ENCODE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CMD_LOAD_ROTOR = 2'd0,
        CMD_LOAD_REFL  = 2'd1,
        CMD_SET        = 2'd2,
        CMD_ENCODE     = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [1:0]       table_select;
        logic [SYM_W-1:0] entry_index;
        logic [SYM_W-1:0] entry_value;
        logic [1:0]       rotor_select;
        logic [SYM_W-1:0] start_position;
        logic [SYM_W-1:0] turnover_point;
        logic [7:0]       char_in;
    } rsc_in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       was_letter;
    } rsc_out_t;

    // Load: sel = table, a = index, b = value. Set: sel = rotor, a = position,
    // b = turnover. Encode: ch = folded byte, letter flags a-z.
    typedef struct packed {
        cmd_kind_t        kind;
        logic             letter;
        logic [ROTOR_W-1:0] sel;
        logic [SYM_W-1:0] a;
        logic [SYM_W-1:0] b;
        logic [7:0]       ch;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } queue_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    // Brings any sum below 64 back into the alphabet.
    function automatic logic [SYM_W-1:0] mod_fold(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] r;
        r = sum;
        if (r >= SUM_W'(2 * ALPHABET_SIZE)) begin
            r = r - SUM_W'(2 * ALPHABET_SIZE);
        end else if (r >= SUM_W'(ALPHABET_SIZE)) begin
            r = r - SUM_W'(ALPHABET_SIZE);
        end
        return r[SYM_W-1:0];
    endfunction

    function automatic logic [SYM_W-1:0] mod_add(input logic [SYM_W-1:0] a,
                                                  input logic [SYM_W-1:0] b);
        return mod_fold({1'b0, a} + {1'b0, b});
    endfunction

    // The subtrahend is always a rotor position, so it stays below the alphabet size.
    function automatic logic [SYM_W-1:0] mod_sub(input logic [SYM_W-1:0] a,
                                                  input logic [SYM_W-1:0] b);
        return mod_fold({1'b0, a} + SUM_W'(ALPHABET_SIZE) - {1'b0, b});
    endfunction

endpackage

[rtl/rotor_substitution_cipher_core.sv]
// Top level of the rotor substitution cipher; uses rsc_pkg, rsc_front, rsc_queue, rsc_back.
// An accepted encode goes through the queue, seven lookup stages and the output register.
// Throughput is one transaction per cycle while results are taken and no load waits.
// A load waits in the queue until encodes in flight have drained from the pipeline, and
// longer while a stalled result side holds the pipeline.
// Reset clears rotor positions, turnover points, queue and pipeline; the wiring
// tables are not cleared and hold nothing defined until loaded.
module rotor_substitution_cipher_core
    import rsc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rsc_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output rsc_out_t m_payload
);

    queue_push_t push;
    queue_head_t head;
    logic        queue_full;
    logic        pop;

    rsc_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .queue_full (queue_full),
        .push_out   (push)
    );

    rsc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_in (push),
        .full    (queue_full),
        .head    (head),
        .pop     (pop)
    );

    rsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

[rtl/rsc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module rsc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 26
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rsc_front.sv]
// Front end: takes input transactions, folds case and sorts them into commands.
// Depends on rsc_pkg; feeds rsc_queue.
module rsc_front
    import rsc_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  rsc_in_t     s_payload,
    input  logic        queue_full,
    output queue_push_t push_out
);

    logic [7:0] folded;
    logic       keep;
    cmd_t       cmd;

    always_comb begin
        folded = s_payload.char_in;
        if (s_payload.char_in >= CHAR_UPPER_A && s_payload.char_in <= CHAR_UPPER_Z) begin
            folded = s_payload.char_in + CASE_GAP;
        end

        cmd.kind   = CMD_ENCODE;
        cmd.letter = (folded >= CHAR_LOWER_A) && (folded <= CHAR_LOWER_Z);
        cmd.sel    = s_payload.table_select;
        cmd.a      = s_payload.entry_index;
        cmd.b      = s_payload.entry_value;
        cmd.ch     = folded;
        keep       = 1'b0;

        case (s_payload.action)
            ACT_LOAD: begin
                cmd.kind = (s_payload.table_select == TABLE_REFLECTOR) ? CMD_LOAD_REFL
                                                                       : CMD_LOAD_ROTOR;
                keep = (s_payload.entry_index <= LAST_SYMBOL)
                    && (s_payload.entry_value <= LAST_SYMBOL);
            end
            ACT_SET: begin
                cmd.kind = CMD_SET;
                cmd.sel  = s_payload.rotor_select;
                cmd.a    = s_payload.start_position;
                cmd.b    = s_payload.turnover_point;
                keep = (s_payload.rotor_select < ROTOR_W'(ROTOR_COUNT))
                    && (s_payload.start_position <= LAST_SYMBOL)
                    && (s_payload.turnover_point <= LAST_SYMBOL);
            end
            ACT_ENCODE: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Items that are out of range are accepted and dropped here.
    assign s_ready       = !queue_full;
    assign push_out.push = s_valid && !queue_full && keep;
    assign push_out.cmd  = cmd;

endmodule

[rtl/rsc_queue.sv]
// Short command queue between the front end and the execution back end.
// Depends on rsc_pkg.
module rsc_queue
    import rsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  queue_push_t push_in,
    output logic        full,
    output queue_head_t head,
    input  logic        pop
);

    cmd_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_in.push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push_in.push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push_in.push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_in.push) begin
            mem_reg[wr_ptr_reg] <= push_in.cmd;
        end
    end

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_in.push |-> !full)
        else $error("Command pushed into a full queue.");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("Command popped from an empty queue.");
`endif

endmodule

[rtl/rsc_back.sv]
// Back end: applies loads and sets, and runs encodes through a seven-stage lookup pipeline.
// Depends on rsc_pkg and rsc_ram; takes commands from rsc_queue.
module rsc_back
    import rsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  queue_head_t head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output rsc_out_t    m_payload
);

    typedef struct packed {
        logic             valid;
        logic             letter;
        logic [7:0]       ch;
        logic [SYM_W-1:0] p0;
        logic [SYM_W-1:0] p1;
        logic [SYM_W-1:0] p2;
    } stage_t;

    stage_t stage_reg  [1:PIPE_STAGES];
    stage_t stage_next [1:PIPE_STAGES];
    stage_t issue_stage;

    logic [SYM_W-1:0] off_reg [ROTOR_COUNT];
    logic [SYM_W-1:0] off_next [ROTOR_COUNT];
    logic [SYM_W-1:0] cp_reg  [ROTOR_COUNT];
    logic [SYM_W-1:0] cp_next [ROTOR_COUNT];
    logic [SYM_W-1:0] off_inc [ROTOR_COUNT];

    logic     out_valid_reg, out_valid_next;
    rsc_out_t out_payload_reg, out_payload_next;

    logic adv;
    logic pipe_empty;
    logic is_load;
    logic issue_encode, issue_letter, issue_load, issue_set;
    logic carry0, carry1;

    logic [TABLE_ADDR_W-1:0] fwd_raddr [ROTOR_COUNT];
    logic [SYM_W-1:0]        fwd_rdata [ROTOR_COUNT];
    logic [TABLE_ADDR_W-1:0] inv_raddr [ROTOR_COUNT];
    logic [SYM_W-1:0]        inv_rdata [ROTOR_COUNT];
    logic [TABLE_ADDR_W-1:0] refl_raddr;
    logic [SYM_W-1:0]        refl_rdata;
    logic [SYM_W-1:0]        issue_x;
    logic [SYM_W-1:0]        result_x;

    // The whole pipeline moves together whenever the output register can take a result.
    assign adv = !out_valid_reg || m_ready;

    always_comb begin
        pipe_empty = 1'b1;
        for (int k = 1; k <= PIPE_STAGES; k++) begin
            if (stage_reg[k].valid) begin
                pipe_empty = 1'b0;
            end
        end
    end

    // A load must not overtake the table reads of encodes still in flight.
    assign is_load      = (head.cmd.kind == CMD_LOAD_ROTOR) || (head.cmd.kind == CMD_LOAD_REFL);
    assign issue_encode = head.valid && (head.cmd.kind == CMD_ENCODE) && adv;
    assign issue_letter = issue_encode && head.cmd.letter;
    assign issue_load   = head.valid && is_load && pipe_empty;
    assign issue_set    = head.valid && (head.cmd.kind == CMD_SET);
    assign pop          = issue_encode || issue_load || issue_set;

    // Rotor positions and stepping.
    always_comb begin
        for (int i = 0; i < ROTOR_COUNT; i++) begin
            off_inc[i]  = mod_add(off_reg[i], SYM_W'(1));
            off_next[i] = off_reg[i];
            cp_next[i]  = cp_reg[i];
            if (issue_set && head.cmd.sel == ROTOR_W'(i)) begin
                off_next[i] = head.cmd.a;
                cp_next[i]  = head.cmd.b;
            end
        end
        carry0 = (off_reg[0] == cp_reg[0]);
        carry1 = (off_reg[1] == cp_reg[1]);
        if (issue_letter) begin
            off_next[0] = off_inc[0];
            if (carry0) begin
                off_next[1] = off_inc[1];
                if (carry1) begin
                    off_next[2] = off_inc[2];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROTOR_COUNT; i++) begin
                off_reg[i] <= '0;
                cp_reg[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < ROTOR_COUNT; i++) begin
                off_reg[i] <= off_next[i];
                cp_reg[i]  <= cp_next[i];
            end
        end
    end

    // Each encode carries a snapshot of the positions it saw at issue.
    always_comb begin
        issue_stage.valid  = issue_encode;
        issue_stage.letter = head.cmd.letter;
        issue_stage.ch     = head.cmd.ch;
        issue_stage.p0     = off_reg[0];
        issue_stage.p1     = off_reg[1];
        issue_stage.p2     = off_reg[2];
        stage_next[1] = adv ? issue_stage : stage_reg[1];
        for (int k = 2; k <= PIPE_STAGES; k++) begin
            stage_next[k] = adv ? stage_reg[k-1] : stage_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= PIPE_STAGES; k++) begin
                stage_reg[k] <= '0;
            end
        end else begin
            for (int k = 1; k <= PIPE_STAGES; k++) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Lookup addresses, one table per stage.
    always_comb begin
        issue_x       = SYM_W'(head.cmd.ch - CHAR_LOWER_A);
        fwd_raddr[0]  = mod_add(issue_x, off_reg[0]);
        fwd_raddr[1]  = mod_add(mod_add(fwd_rdata[0], stage_reg[1].p0), stage_reg[1].p1);
        fwd_raddr[2]  = mod_add(mod_add(fwd_rdata[1], stage_reg[2].p1), stage_reg[2].p2);
        refl_raddr    = mod_add(fwd_rdata[2], stage_reg[3].p2);
        inv_raddr[2]  = mod_sub(refl_rdata, stage_reg[4].p2);
        inv_raddr[1]  = mod_sub(mod_sub(inv_rdata[2], stage_reg[5].p2), stage_reg[5].p1);
        inv_raddr[0]  = mod_sub(mod_sub(inv_rdata[1], stage_reg[6].p1), stage_reg[6].p0);
        result_x      = mod_sub(inv_rdata[0], stage_reg[7].p0);
    end

    for (genvar r = 0; r < ROTOR_COUNT; r++) begin : g_rotor
        logic wr_rotor;
        assign wr_rotor = issue_load && (head.cmd.kind == CMD_LOAD_ROTOR)
                       && (head.cmd.sel == ROTOR_W'(r));

        rsc_ram #(.WIDTH(SYM_W), .DEPTH(ALPHABET_SIZE)) u_fwd (
            .aclk    (aclk),
            .wr_en   (wr_rotor),
            .wr_addr (head.cmd.a),
            .wr_data (head.cmd.b),
            .rd_en   (adv),
            .rd_addr (fwd_raddr[r]),
            .rd_data (fwd_rdata[r])
        );

        rsc_ram #(.WIDTH(SYM_W), .DEPTH(ALPHABET_SIZE)) u_inv (
            .aclk    (aclk),
            .wr_en   (wr_rotor),
            .wr_addr (head.cmd.b),
            .wr_data (head.cmd.a),
            .rd_en   (adv),
            .rd_addr (inv_raddr[r]),
            .rd_data (inv_rdata[r])
        );
    end

    rsc_ram #(.WIDTH(SYM_W), .DEPTH(ALPHABET_SIZE)) u_refl (
        .aclk    (aclk),
        .wr_en   (issue_load && (head.cmd.kind == CMD_LOAD_REFL)),
        .wr_addr (head.cmd.a),
        .wr_data (head.cmd.b),
        .rd_en   (adv),
        .rd_addr (refl_raddr),
        .rd_data (refl_rdata)
    );

    // Output register.
    always_comb begin
        out_valid_next   = out_valid_reg;
        out_payload_next = out_payload_reg;
        if (adv) begin
            out_valid_next              = stage_reg[PIPE_STAGES].valid;
            out_payload_next.was_letter = stage_reg[PIPE_STAGES].letter;
            out_payload_next.char_out   = stage_reg[PIPE_STAGES].letter
                                        ? CHAR_LOWER_A + {3'b000, result_x}
                                        : stage_reg[PIPE_STAGES].ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_payload_reg <= out_payload_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_payload_reg;

`ifndef NO_ASSERTIONS
    a_offsets_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (off_reg[0] <= LAST_SYMBOL) && (off_reg[1] <= LAST_SYMBOL)
        && (off_reg[2] <= LAST_SYMBOL))
        else $error("Rotor position left the alphabet.");

    a_letter_steps_rotor0: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_letter |=> (off_reg[0] == $past(off_inc[0])))
        else $error("Rotor 0 did not step after an enciphered letter.");

    a_rotor2_needs_rotor1: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(issue_set) && (off_reg[2] != $past(off_reg[2])))
        |-> (off_reg[1] != $past(off_reg[1])))
        else $error("Rotor 2 stepped without rotor 1 stepping.");

    a_letter_result_lowercase: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && stage_reg[PIPE_STAGES].valid && stage_reg[PIPE_STAGES].letter)
        |=> (m_payload.char_out >= CHAR_LOWER_A) && (m_payload.char_out <= CHAR_LOWER_Z))
        else $error("Enciphered letter is not a lowercase letter.");
`endif

endmodule

[tb/sv/rotor_substitution_cipher_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rotor_substitution_cipher_core: a directed table, then random traffic.
// Depends on rsc_pkg and the block's RTL; the cipher is predicted locally and checked in order.
module rotor_substitution_cipher_core_tb;
    import rsc_pkg::*;

    localparam int         CLK_HALF_NS  = 2;
    localparam int         RESET_CYCLES = 4;
    localparam int         RANDOM_ITEMS = 420;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         LONG_HOLD    = 300;
    localparam int         HOLD_AFTER   = 100;
    localparam int         MAX_REPORTS  = 10;
    localparam longint     RUN_LIMIT_NS = 4_000_000;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_SILENT
    } row_check_t;

    typedef struct packed {
        rsc_in_t    item;
        row_check_t check;
        rsc_out_t   result;
    } dir_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rsc_in_t  s_payload;
    logic     m_valid;
    logic     m_ready;
    rsc_out_t m_payload;

    // Local copy of the cipher state, advanced as each transaction is accepted.
    logic [SYM_W-1:0] fwd_wiring  [ROTOR_COUNT][ALPHABET_SIZE];
    logic [SYM_W-1:0] inv_wiring  [ROTOR_COUNT][ALPHABET_SIZE];
    logic [SYM_W-1:0] refl_wiring [ALPHABET_SIZE];
    logic [SYM_W-1:0] rotor_pos   [ROTOR_COUNT];
    logic [SYM_W-1:0] turn_pos    [ROTOR_COUNT];

    rsc_out_t pending_ciphertext[$];
    dir_row_t dir_rows[$];
    int       fail_count;
    int       results_seen;
    int       random_sent;
    bit       no_gap_phase;

    rotor_substitution_cipher_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        aclk = 1'b1;
        #(CLK_HALF_NS);
        aclk = 1'b0;
        #(CLK_HALF_NS);
    end

    function automatic logic [SYM_W-1:0] wrap_symbol(input int v);
        int m;
        m = v % ALPHABET_SIZE;
        if (m < 0) begin
            m = m + ALPHABET_SIZE;
        end
        return SYM_W'(m);
    endfunction

    // Applies one transaction to the local state; returns 1 when it yields a result.
    function automatic bit encipher_item(input rsc_in_t item, output rsc_out_t result);
        int         x;
        int         r;
        logic [7:0] c;
        bit         carry;
        bit         produces;
        result   = '0;
        produces = 1'b0;
        case (item.action)
            ACT_LOAD: begin
                if (item.entry_index < ALPHABET_SIZE && item.entry_value < ALPHABET_SIZE) begin
                    if (item.table_select == TABLE_REFLECTOR) begin
                        refl_wiring[item.entry_index] = item.entry_value;
                    end else begin
                        fwd_wiring[item.table_select][item.entry_index] = item.entry_value;
                        inv_wiring[item.table_select][item.entry_value] = item.entry_index;
                    end
                end
            end
            ACT_SET: begin
                if (item.rotor_select < ROTOR_COUNT && item.start_position < ALPHABET_SIZE &&
                    item.turnover_point < ALPHABET_SIZE) begin
                    rotor_pos[item.rotor_select] = item.start_position;
                    turn_pos[item.rotor_select]  = item.turnover_point;
                end
            end
            ACT_ENCODE: begin
                produces = 1'b1;
                c = item.char_in;
                if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
                    c = c + CASE_GAP;
                end
                if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
                    x = int'(c - CHAR_LOWER_A);
                    for (r = 0; r < ROTOR_COUNT; r++) begin
                        x = wrap_symbol(int'(fwd_wiring[r][wrap_symbol(x + int'(rotor_pos[r]))])
                                        + int'(rotor_pos[r]));
                    end
                    x = refl_wiring[x];
                    for (r = ROTOR_COUNT - 1; r >= 0; r--) begin
                        x = wrap_symbol(int'(inv_wiring[r][wrap_symbol(x - int'(rotor_pos[r]))])
                                        - int'(rotor_pos[r]));
                    end
                    result.char_out   = 8'(x) + CHAR_LOWER_A;
                    result.was_letter = 1'b1;
                    // Each rotor carries only if it sat on its turnover point before stepping.
                    carry = 1'b1;
                    for (r = 0; r < ROTOR_COUNT && carry; r++) begin
                        carry        = (rotor_pos[r] == turn_pos[r]);
                        rotor_pos[r] = wrap_symbol(int'(rotor_pos[r]) + 1);
                    end
                end else begin
                    result.char_out   = c;
                    result.was_letter = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return produces;
    endfunction

    function automatic rsc_in_t noise_item();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(rsc_in_t)-1:0];
    endfunction

    function automatic rsc_in_t mk_load(input logic [1:0] sel, input logic [SYM_W-1:0] idx,
                                        input logic [SYM_W-1:0] val);
        rsc_in_t item;
        item              = noise_item();
        item.action       = ACT_LOAD;
        item.table_select = sel;
        item.entry_index  = idx;
        item.entry_value  = val;
        return item;
    endfunction

    function automatic rsc_in_t mk_set(input logic [1:0] rotor, input logic [SYM_W-1:0] pos,
                                       input logic [SYM_W-1:0] turn);
        rsc_in_t item;
        item                = noise_item();
        item.action         = ACT_SET;
        item.rotor_select   = rotor;
        item.start_position = pos;
        item.turnover_point = turn;
        return item;
    endfunction

    function automatic rsc_in_t mk_encode(input logic [7:0] ch);
        rsc_in_t item;
        item         = noise_item();
        item.action  = ACT_ENCODE;
        item.char_in = ch;
        return item;
    endfunction

    function automatic rsc_out_t passthrough(input logic [7:0] ch);
        rsc_out_t result;
        result.char_out   = ch;
        result.was_letter = 1'b0;
        return result;
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A;
        return base + 8'($urandom_range(0, ALPHABET_SIZE - 1));
    endfunction

    // Mostly short idle gaps, now and then a long one.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gap_phase || pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_row(input rsc_in_t item, input row_check_t check,
                                    input rsc_out_t result);
        dir_row_t row;
        row.item   = item;
        row.check  = check;
        row.result = result;
        dir_rows.push_back(row);
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            report_failure($sformatf("%s expected %h, got %h", name, want, got));
        end
    endtask

    // Valid is only lowered when a gap follows, so it never drops and rises in one step.
    task automatic send_item(input rsc_in_t item, input int gap, input row_check_t check,
                             input rsc_out_t typed_result);
        rsc_out_t predicted;
        bit       produces;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        produces = encipher_item(item, predicted);
        if (check == ROW_PREDICT && produces) begin
            pending_ciphertext.push_back(predicted);
        end else if (check == ROW_TYPED) begin
            pending_ciphertext.push_back(typed_result);
        end
    endtask

    task automatic send_rand(input rsc_in_t item);
        send_item(item, idle_len(), ROW_PREDICT, '0);
        random_sent++;
    endtask

    // Writes a whole table as a random permutation, so every entry is defined afterwards.
    task automatic load_full_table(input logic [1:0] sel);
        logic [SYM_W-1:0] perm [ALPHABET_SIZE];
        logic [SYM_W-1:0] tmp;
        int               i;
        int               j;
        for (i = 0; i < ALPHABET_SIZE; i++) begin
            perm[i] = SYM_W'(i);
        end
        for (i = ALPHABET_SIZE - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (i = 0; i < ALPHABET_SIZE; i++) begin
            send_rand(mk_load(sel, SYM_W'(i), perm[i]));
        end
    endtask

    always @(posedge aclk) begin : result_check
        rsc_out_t want;
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            results_seen++;
            if (pending_ciphertext.size() == 0) begin
                report_failure($sformatf("result %h arrived with nothing pending", m_payload));
            end else begin
                want = pending_ciphertext.pop_front();
                check_field("char_out", want.char_out, m_payload.char_out);
                check_field("was_letter", 8'(want.was_letter), 8'(m_payload.was_letter));
            end
        end
    end

    // Result side: runs of readiness and stalls, plus one long hold-off to back up the block.
    initial begin : result_sink
        int hold_left;
        int run_left;
        bit long_hold_done;
        hold_left      = 0;
        run_left       = 0;
        long_hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                run_left       = 0;
            end
            if (hold_left == 0 && run_left == 0) begin
                if ($urandom_range(0, 1)) begin
                    run_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
                end else begin
                    hold_left = 1 + idle_len();
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= 1'b1;
                run_left--;
            end
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("rotor_substitution_cipher_core_tb failed");
        $finish;
    end

    initial begin : stimulus
        int         k;
        int         pick;
        int         burst;
        logic [7:0] ch;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_payload    = '0;
        m_ready      = 1'b0;
        fail_count   = 0;
        results_seen = 0;
        random_sent  = 0;
        no_gap_phase = 1'b0;
        for (k = 0; k < ROTOR_COUNT; k++) begin
            rotor_pos[k] = '0;
            turn_pos[k]  = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < ROTOR_COUNT; k++) begin
            load_full_table(2'(k));
        end
        load_full_table(TABLE_REFLECTOR);

        // Directed part. Letters right after reset start with every rotor on its turnover point.
        add_row(mk_encode(random_letter()), ROW_PREDICT, '0);
        add_row(mk_encode(8'h00), ROW_TYPED, passthrough(8'h00));
        add_row(mk_encode(8'hFF), ROW_TYPED, passthrough(8'hFF));
        add_row(mk_encode(8'h80), ROW_TYPED, passthrough(8'h80));
        add_row(mk_encode(CHAR_UPPER_A - 8'd1), ROW_TYPED, passthrough(CHAR_UPPER_A - 8'd1));
        add_row(mk_encode(CHAR_UPPER_Z + 8'd1), ROW_TYPED, passthrough(CHAR_UPPER_Z + 8'd1));
        add_row(mk_encode(CHAR_LOWER_A - 8'd1), ROW_TYPED, passthrough(CHAR_LOWER_A - 8'd1));
        add_row(mk_encode(CHAR_LOWER_Z + 8'd1), ROW_TYPED, passthrough(CHAR_LOWER_Z + 8'd1));
        add_row(mk_encode(CHAR_UPPER_A), ROW_PREDICT, '0);
        add_row(mk_encode(CHAR_UPPER_Z), ROW_PREDICT, '0);
        add_row(mk_encode(CHAR_LOWER_A), ROW_PREDICT, '0);
        add_row(mk_encode(CHAR_LOWER_Z), ROW_PREDICT, '0);
        // A double carry: both fast rotors sit on their last position and turnover point.
        add_row(mk_set(2'd0, LAST_SYMBOL, LAST_SYMBOL), ROW_SILENT, '0);
        add_row(mk_set(2'd1, LAST_SYMBOL, LAST_SYMBOL), ROW_SILENT, '0);
        add_row(mk_set(2'd2, '0, '0), ROW_SILENT, '0);
        add_row(mk_encode(random_letter()), ROW_PREDICT, '0);
        add_row(mk_encode(random_letter()), ROW_PREDICT, '0);
        // Out-of-range loads and sets, and the unused action, must leave the state alone.
        add_row(mk_set(2'd3, 5'd5, 5'd5), ROW_SILENT, '0);
        add_row(mk_set(2'd0, 5'd26, 5'd0), ROW_SILENT, '0);
        add_row(mk_set(2'd0, 5'd0, 5'd31), ROW_SILENT, '0);
        add_row(mk_load(2'd0, 5'd26, 5'd0), ROW_SILENT, '0);
        add_row(mk_load(TABLE_REFLECTOR, 5'd0, 5'd31), ROW_SILENT, '0);
        add_row(mk_set(ACT_UNUSED, 5'd0, 5'd0) ^ {ACT_SET ^ ACT_UNUSED, 32'd0}, ROW_SILENT, '0);
        add_row(mk_encode(random_letter()), ROW_PREDICT, '0);
        add_row(mk_load(2'd2, LAST_SYMBOL, LAST_SYMBOL), ROW_SILENT, '0);
        add_row(mk_encode(random_letter()), ROW_PREDICT, '0);
        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].item, idle_len(), dir_rows[k].check, dir_rows[k].result);
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            no_gap_phase = (random_sent >= 250 && random_sent < 330);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_rand(mk_encode(random_letter()));
            end else if (pick < 67) begin
                send_rand(mk_encode(8'($urandom_range(0, 255))));
            end else if (pick < 77) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_rand(mk_set(2'($urandom), 5'($urandom), 5'($urandom)));
                end else begin
                    send_rand(mk_set(2'($urandom_range(0, ROTOR_COUNT - 1)),
                                     5'($urandom_range(0, ALPHABET_SIZE - 1)),
                                     5'($urandom_range(0, ALPHABET_SIZE - 1))));
                end
            end else if (pick < 87) begin
                send_rand(mk_load(2'($urandom), 5'($urandom), 5'($urandom)));
            end else if (pick < 91) begin
                send_rand(mk_set(2'($urandom), 5'($urandom), 5'($urandom))
                          ^ {ACT_SET ^ ACT_UNUSED, 32'd0});
            end else if (pick < 93) begin
                load_full_table(2'($urandom));
            end else begin
                // A message: fresh key settings, then a run of mostly letters.
                for (k = 0; k < ROTOR_COUNT; k++) begin
                    send_rand(mk_set(2'(k), 5'($urandom_range(0, ALPHABET_SIZE - 1)),
                                     5'($urandom_range(0, ALPHABET_SIZE - 1))));
                end
                burst = $urandom_range(8, 24);
                for (k = 0; k < burst; k++) begin
                    ch = ($urandom_range(0, 9) == 0) ? CHAR_SPACE : random_letter();
                    send_rand(mk_encode(ch));
                end
            end
        end
        no_gap_phase = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_ciphertext.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("rotor_substitution_cipher_core_tb passed");
        end else begin
            $display("rotor_substitution_cipher_core_tb failed");
        end
        $finish;
    end

endmodule

[rotor_substitution_cipher_core.f]
rtl/rsc_pkg.sv
rtl/rsc_ram.sv
rtl/rsc_front.sv
rtl/rsc_queue.sv
rtl/rsc_back.sv
rtl/rotor_substitution_cipher_core.sv
tb/sv/rotor_substitution_cipher_core_tb.sv
